/* rtl/sorted_key_table_defines.svh */
// assertion macros for the sorted key table checker
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define SKT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_key_table: same-cycle check failed");

// next-cycle implication, sampled on the rising clock edge outside reset
`define SKT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_key_table: next-cycle check failed");

`endif

/* rtl/skt_pkg.sv */
// shared constants, codes and controller/datapath interface types
package skt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_IN_W    = 32;
    localparam int ACT_W       = 2;
    localparam int POS_W       = 8;
    localparam int ST_W        = 3;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK           = 3'd0;
    localparam logic [ST_W-1:0] ST_DUPLICATE    = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND    = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL         = 3'd3;
    localparam logic [ST_W-1:0] ST_NONE_REMOVED = 3'd4;

    // which result the datapath loads into the output register
    typedef enum logic [2:0] {
        RS_NONE,
        RS_DUP,
        RS_NOT_FOUND,
        RS_FULL,
        RS_NOTHING,
        RS_POS_LO,
        RS_POS_START
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     rd_mid;
        logic     cmp_step;
        logic     ptr_init_up;
        logic     rd_up;
        logic     wr_up;
        logic     write_key;
        logic     rm_init;
        logic     rd_dn;
        logic     wr_dn;
        logic     rm_done;
        logic     res_load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             full;
        logic             empty;
        logic             count_zero;
        logic             dupes;
        logic             closest;
        logic             search_done;
        logic             eq;
        logic             up_done;
        logic             dn_done;
        logic             out_busy;
    } stat_t;

endpackage

/* rtl/skt_ram.sv */
// generic single-write single-read ram with registered read data
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/skt_ctrl.sv */
// sequencing state machine for search, shift and result hand-off
module skt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  skt_pkg::stat_t stat,
    output skt_pkg::cmd_t  cmd
);

    import skt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_RESOLVE,
        S_SHIFT_UP_RD,
        S_SHIFT_UP_WR,
        S_SHIFT_DN_RD,
        S_SHIFT_DN_WR,
        S_FINISH
    } state_t;

    state_t   state_reg, state_next;
    res_sel_t res_sel_reg, res_sel_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        res_sel_next = res_sel_reg;
        cmd          = '0;
        cmd.res_sel  = res_sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.act)
                    ACT_INSERT:
                    begin
                        if (stat.full)
                        begin
                            res_sel_next = RS_FULL;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SEARCH_RD;
                        end
                    end
                    ACT_FIND:
                    begin
                        if (stat.empty)
                        begin
                            res_sel_next = RS_NOT_FOUND;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SEARCH_RD;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (stat.empty || stat.count_zero)
                        begin
                            res_sel_next = RS_NOTHING;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            cmd.rm_init = 1'b1;
                            state_next  = S_SHIFT_DN_RD;
                        end
                    end
                    default:
                    begin
                        res_sel_next = RS_NONE;
                        state_next   = S_FINISH;
                    end
                endcase
            end
            S_SEARCH_RD:
            begin
                if (stat.search_done)
                begin
                    state_next = S_RESOLVE;
                end
                else
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = S_SEARCH_CMP;
                end
            end
            S_SEARCH_CMP:
            begin
                cmd.cmp_step = 1'b1;
                state_next   = S_SEARCH_RD;
            end
            S_RESOLVE:
            begin
                if (stat.act == ACT_INSERT)
                begin
                    if (!stat.dupes && stat.eq)
                    begin
                        res_sel_next = RS_DUP;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        cmd.ptr_init_up = 1'b1;
                        state_next      = S_SHIFT_UP_RD;
                    end
                end
                else
                begin
                    res_sel_next = (stat.closest || stat.eq) ? RS_POS_LO : RS_NOT_FOUND;
                    state_next   = S_FINISH;
                end
            end
            S_SHIFT_UP_RD:
            begin
                if (stat.up_done)
                begin
                    cmd.write_key = 1'b1;
                    res_sel_next  = RS_POS_LO;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.rd_up  = 1'b1;
                    state_next = S_SHIFT_UP_WR;
                end
            end
            S_SHIFT_UP_WR:
            begin
                cmd.wr_up  = 1'b1;
                state_next = S_SHIFT_UP_RD;
            end
            S_SHIFT_DN_RD:
            begin
                if (stat.dn_done)
                begin
                    cmd.rm_done  = 1'b1;
                    res_sel_next = RS_POS_START;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.rd_dn  = 1'b1;
                    state_next = S_SHIFT_DN_WR;
                end
            end
            S_SHIFT_DN_WR:
            begin
                cmd.wr_dn  = 1'b1;
                state_next = S_SHIFT_DN_RD;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            res_sel_reg <= RS_NONE;
        end
        else
        begin
            state_reg   <= state_next;
            res_sel_reg <= res_sel_next;
        end
    end

endmodule

/* rtl/skt_datapath.sv */
// key store, search bounds, copy pointer and output register
module skt_datapath #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  skt_pkg::cmd_t                  cmd,
    output skt_pkg::stat_t                 stat,
    input  logic [skt_pkg::ACT_W-1:0]      action,
    input  logic signed [skt_pkg::KEY_IN_W-1:0] key,
    input  logic                           allow_dupes,
    input  logic                           closest,
    input  logic [skt_pkg::IDX_W-1:0]      start_index,
    input  logic [skt_pkg::CNT_W-1:0]      remove_count,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [skt_pkg::POS_W-1:0] position,
    output logic [skt_pkg::ST_W-1:0]       status,
    output logic [skt_pkg::CNT_W-1:0]      used_count
);

    import skt_pkg::*;

    // control state
    logic [CNT_W-1:0] used_reg, used_next;
    logic             out_valid_reg, out_valid_next;

    // item and working registers
    logic [ACT_W-1:0]     act_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic                 dupes_reg;
    logic                 closest_reg;
    logic [CNT_W-1:0]     start_reg, start_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic                 eq_reg, eq_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;

    // output payload
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic [ST_W-1:0]         st_reg, st_next;
    logic [CNT_W-1:0]        ucnt_reg, ucnt_next;

    logic [CNT_W-1:0]     mid;
    logic [CNT_W:0]       src;
    logic [CNT_W-1:0]     last_idx;
    logic [CNT_W-1:0]     start_clamp;
    logic [CNT_W-1:0]     avail;
    logic [CNT_W-1:0]     count_clamp;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign src = {1'b0, ptr_reg} + {1'b0, count_reg};

    // clamp the removal window to the entries present
    assign last_idx    = used_reg - CNT_W'(1);
    assign start_clamp = (start_reg > last_idx) ? last_idx : start_reg;
    assign avail       = used_reg - start_clamp;
    assign count_clamp = (count_reg > avail) ? avail : count_reg;

    always_comb
    begin
        ram_re    = cmd.rd_mid | cmd.rd_up | cmd.rd_dn;
        ram_raddr = mid[IDX_W-1:0];
        if (cmd.rd_up)
        begin
            ram_raddr = IDX_W'(ptr_reg - CNT_W'(1));
        end
        else if (cmd.rd_dn)
        begin
            ram_raddr = src[IDX_W-1:0];
        end

        ram_we    = cmd.write_key | cmd.wr_up | cmd.wr_dn;
        ram_waddr = ptr_reg[IDX_W-1:0];
        ram_wdata = ram_rdata;
        if (cmd.write_key)
        begin
            ram_waddr = lo_reg[IDX_W-1:0];
            ram_wdata = key_reg;
        end
    end

    skt_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_skt_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        used_next      = used_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        eq_next        = eq_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        st_next        = st_reg;
        ucnt_next      = ucnt_reg;
        out_valid_next = out_valid_reg & ~out_ready;

        if (cmd.load)
        begin
            start_next = CNT_W'(start_index);
            count_next = remove_count;
            lo_next    = '0;
            hi_next    = used_reg;
            eq_next    = 1'b0;
        end
        if (cmd.cmp_step)
        begin
            if ($signed(ram_rdata) < $signed(key_reg))
            begin
                lo_next = mid + CNT_W'(1);
            end
            else
            begin
                hi_next = mid;
                eq_next = (ram_rdata == key_reg);
            end
        end
        if (cmd.ptr_init_up)
        begin
            ptr_next = used_reg;
        end
        if (cmd.wr_up)
        begin
            ptr_next = ptr_reg - CNT_W'(1);
        end
        if (cmd.write_key)
        begin
            used_next = used_reg + CNT_W'(1);
        end
        if (cmd.rm_init)
        begin
            start_next = start_clamp;
            count_next = count_clamp;
            ptr_next   = start_clamp;
        end
        if (cmd.wr_dn)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
        if (cmd.rm_done)
        begin
            used_next = used_reg - count_reg;
        end
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
            ucnt_next      = used_reg;
            pos_next       = '1;
            case (cmd.res_sel)
                RS_NONE:      st_next = ST_OK;
                RS_DUP:       st_next = ST_DUPLICATE;
                RS_NOT_FOUND: st_next = ST_NOT_FOUND;
                RS_FULL:      st_next = ST_FULL;
                RS_NOTHING:   st_next = ST_NONE_REMOVED;
                RS_POS_LO:
                begin
                    st_next  = ST_OK;
                    pos_next = POS_W'(lo_reg);
                end
                RS_POS_START:
                begin
                    st_next  = ST_OK;
                    pos_next = POS_W'(start_reg);
                end
                default:      st_next = ST_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg     <= action;
            key_reg     <= KEY_WIDTH'($unsigned(key));
            dupes_reg   <= allow_dupes;
            closest_reg <= closest;
        end
        start_reg <= start_next;
        count_reg <= count_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        eq_reg    <= eq_next;
        ptr_reg   <= ptr_next;
        pos_reg   <= pos_next;
        st_reg    <= st_next;
        ucnt_reg  <= ucnt_next;
    end

    assign stat.act         = act_reg;
    assign stat.full        = (used_reg >= CNT_W'(TABLE_DEPTH));
    assign stat.empty       = (used_reg == '0);
    assign stat.count_zero  = (count_reg == '0);
    assign stat.dupes       = dupes_reg;
    assign stat.closest     = closest_reg;
    assign stat.search_done = (lo_reg == hi_reg);
    assign stat.eq          = eq_reg;
    assign stat.up_done     = (ptr_reg == lo_reg);
    assign stat.dn_done     = (src >= {1'b0, used_reg});
    assign stat.out_busy    = out_valid_reg & ~out_ready;

    assign out_valid  = out_valid_reg;
    assign position   = pos_reg;
    assign status     = st_reg;
    assign used_count = ucnt_reg;

endmodule

/* rtl/sorted_key_table.sv */
// top level of the sorted key table: controller plus datapath
//
// channel  direction  handshake            payload
// input    in         in_valid / in_ready  action, key, allow_dupes, closest,
//                                          start_index, remove_count
// output   out        out_valid / out_ready position, status, used_count
//
// one item at a time; in_ready is high only while the controller is idle
// find runs a binary search over the n stored keys, with one ram read and one
// compare per search step; insert adds the key write plus a read and a write
// for each key moved up; remove does a read and a write for each key moved
// down (one read, one write port)
// reset clears the entry count and the output valid; the key ram is not cleared
// a finished result waits in the output register; the next item is taken
// meanwhile and only holds at its end if that result is still not taken
module sorted_key_table #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [skt_pkg::ACT_W-1:0]             action,
    input  logic signed [skt_pkg::KEY_IN_W-1:0]   key,
    input  logic                                  allow_dupes,
    input  logic                                  closest,
    input  logic [skt_pkg::IDX_W-1:0]             start_index,
    input  logic [skt_pkg::CNT_W-1:0]             remove_count,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [skt_pkg::POS_W-1:0]      position,
    output logic [skt_pkg::ST_W-1:0]              status,
    output logic [skt_pkg::CNT_W-1:0]             used_count
);

    import skt_pkg::*;

    // command and status between the sequencer and the datapath
    cmd_t  cmd;
    stat_t stat;

    // sequencer: search steps, shift loops, result hand-off
    skt_ctrl u_skt_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: key ram, bounds, copy pointer, output register
    skt_datapath #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_skt_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .key          (key),
        .allow_dupes  (allow_dupes),
        .closest      (closest),
        .start_index  (start_index),
        .remove_count (remove_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .position     (position),
        .status       (status),
        .used_count   (used_count)
    );

endmodule

/* rtl/skt_checker.sv */
// port-level checks for the sorted key table, bound to the top level
`include "sorted_key_table_defines.svh"

module skt_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [skt_pkg::POS_W-1:0]    position,
    input logic [skt_pkg::ST_W-1:0]            status,
    input logic [skt_pkg::CNT_W-1:0]           used_count
);

    import skt_pkg::*;

    logic signed [POS_W-1:0]          pos_limit;
    logic                             pos_given;
    logic                             pos_ok;
    logic [POS_W+ST_W+CNT_W-1:0]      out_payload;

    assign pos_limit   = $signed({1'b0, used_count});
    assign pos_given   = out_valid && (position != -8'sd1);
    assign pos_ok      = (position >= 8'sd0) && (position <= pos_limit);
    assign out_payload = {position, status, used_count};

    // any error status comes with no position
    `SKT_ASSERT_NOW(a_err_no_pos, out_valid && (status != ST_OK), position == -8'sd1)

    // a reported position is never above the count of entries in use
    `SKT_ASSERT_NOW(a_pos_in_range, pos_given, pos_ok)

    // one item at a time: no second item right after an accept
    `SKT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

    // a stalled result holds its payload
    `SKT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

endmodule

bind sorted_key_table skt_checker u_skt_checker (.*);

/* tb/tb.sv */
// testbench for the sorted key table: queued driver, clocked monitor and shadow-table scoreboard
module tb;

    import skt_pkg::*;

    // action code that the block accepts but does nothing with
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int SEGMENT_ITEMS  = 50;
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLD_CYCLES    = 600;
    localparam int TIMEOUT_CYCLES = 1000000;

    typedef struct packed {
        logic [ACT_W-1:0]           action;
        logic signed [KEY_IN_W-1:0] key;
        logic                       allow_dupes;
        logic                       closest;
        logic [IDX_W-1:0]           start_index;
        logic [CNT_W-1:0]           remove_count;
    } table_request_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [ST_W-1:0]         status;
        logic [CNT_W-1:0]        used_count;
    } table_reply_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [ACT_W-1:0]           action = '0;
    logic signed [KEY_IN_W-1:0] key = '0;
    logic                       allow_dupes = 1'b0;
    logic                       closest = 1'b0;
    logic [IDX_W-1:0]           start_index = '0;
    logic [CNT_W-1:0]           remove_count = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [POS_W-1:0]    position;
    logic [ST_W-1:0]            status;
    logic [CNT_W-1:0]           used_count;

    // stimulus waiting to be offered, and replies predicted for accepted items
    table_request_t pending_requests[$];
    table_reply_t   predicted_replies[$];

    // shadow copy of the table, kept in step with the accepted items
    logic signed [KEY_IN_W-1:0] shadow_keys [TABLE_DEPTH];
    int                         shadow_used = 0;

    int  items_accepted = 0;
    int  items_total = 0;
    int  mismatch_count = 0;
    // long receiver hold-off, so the block fills up and drops in_ready
    logic hold_off = 1'b0;

    sorted_key_table DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .key          (key),
        .allow_dupes  (allow_dupes),
        .closest      (closest),
        .start_index  (start_index),
        .remove_count (remove_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .position     (position),
        .status       (status),
        .used_count   (used_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // first entry not less than k among the used entries
    function automatic int lower_bound(logic signed [KEY_IN_W-1:0] k);
        int idx;
        idx = shadow_used;
        for (int i = shadow_used - 1; i >= 0; i--)
        begin
            if (shadow_keys[i] >= k)
                idx = i;
        end
        return idx;
    endfunction

    // applies one item to the shadow table and returns the reply it causes
    function automatic table_reply_t apply_to_shadow(table_request_t rq);
        table_reply_t rp;
        int           lb;
        int           first;
        int           span;
        rp.position = '1;
        rp.status   = ST_OK;
        case (rq.action)
            ACT_INSERT:
            begin
                // full is checked ahead of the duplicate check
                if (shadow_used >= TABLE_DEPTH)
                    rp.status = ST_FULL;
                else
                begin
                    lb = lower_bound(rq.key);
                    if (!rq.allow_dupes && lb < shadow_used && shadow_keys[lb] == rq.key)
                        rp.status = ST_DUPLICATE;
                    else
                    begin
                        for (int i = shadow_used; i > lb; i--)
                            shadow_keys[i] = shadow_keys[i-1];
                        shadow_keys[lb] = rq.key;
                        shadow_used++;
                        rp.position = POS_W'(lb);
                    end
                end
            end
            ACT_FIND:
            begin
                if (shadow_used == 0)
                    rp.status = ST_NOT_FOUND;
                else
                begin
                    lb = lower_bound(rq.key);
                    if (rq.closest)
                        rp.position = POS_W'(lb);
                    else if (lb < shadow_used && shadow_keys[lb] == rq.key)
                        rp.position = POS_W'(lb);
                    else
                        rp.status = ST_NOT_FOUND;
                end
            end
            ACT_REMOVE:
            begin
                if (shadow_used == 0 || rq.remove_count == '0)
                    rp.status = ST_NONE_REMOVED;
                else
                begin
                    // clamp the start to the last entry, the count to the tail
                    first = int'(rq.start_index);
                    if (first > shadow_used - 1)
                        first = shadow_used - 1;
                    span = int'(rq.remove_count);
                    if (span > shadow_used - first)
                        span = shadow_used - first;
                    for (int i = first; i + span < shadow_used; i++)
                        shadow_keys[i] = shadow_keys[i+span];
                    shadow_used -= span;
                    rp.position = POS_W'(first);
                end
            end
            default:
            begin
                // spare code: no change
            end
        endcase
        rp.used_count = CNT_W'(shadow_used);
        return rp;
    endfunction

    function automatic void queue_request(logic [ACT_W-1:0] act, logic signed [KEY_IN_W-1:0] k,
                                          logic d, logic c, logic [IDX_W-1:0] s,
                                          logic [CNT_W-1:0] n);
        table_request_t rq;
        rq.action       = act;
        rq.key          = k;
        rq.allow_dupes  = d;
        rq.closest      = c;
        rq.start_index  = s;
        rq.remove_count = n;
        pending_requests.push_back(rq);
    endfunction

    // keys cluster on a few values so duplicates and exact finds are common
    function automatic logic signed [KEY_IN_W-1:0] random_key();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return $urandom;
        else if (pick < 5)
        begin
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        else
            return $signed($urandom_range(20)) - 32'sd10;
    endfunction

    // mostly short ranges, with zero, the whole table and anything in between
    function automatic logic [CNT_W-1:0] random_remove_count();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return CNT_W'(TABLE_DEPTH);
        else if (pick == 2)
            return CNT_W'($urandom_range(TABLE_DEPTH));
        else
            return CNT_W'($urandom_range(4, 1));
    endfunction

    // idle percentage per phase: sender 37 then 76, receiver 76 then 37, then none
    function automatic int idle_percent(bit receiver_side);
        if (items_accepted < items_total / 3)
            return receiver_side ? 76 : 37;
        else if (items_accepted < (2 * items_total) / 3)
            return receiver_side ? 37 : 76;
        else
            return 0;
    endfunction

    // driver: offers the next item once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= idle_percent(1'b0))
            begin
                table_request_t rq;
                rq = pending_requests.pop_front();
                action       <= rq.action;
                key          <= rq.key;
                allow_dupes  <= rq.allow_dupes;
                closest      <= rq.closest;
                start_index  <= rq.start_index;
                remove_count <= rq.remove_count;
                in_valid     <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver ready, random per phase and forced low during the hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= idle_percent(1'b1));
    end

    // monitor: predicts on every accepted item, checks every accepted reply
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                table_request_t rq;
                rq.action       = action;
                rq.key          = key;
                rq.allow_dupes  = allow_dupes;
                rq.closest      = closest;
                rq.start_index  = start_index;
                rq.remove_count = remove_count;
                predicted_replies.push_back(apply_to_shadow(rq));
                items_accepted <= items_accepted + 1;
            end
            if (out_valid && out_ready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $display("%0t unexpected reply: position %0d status %0d used_count %0d",
                             $time, position, status, used_count);
                    mismatch_count++;
                end
                else
                begin
                    table_reply_t rp;
                    rp = predicted_replies.pop_front();
                    if (position !== rp.position)
                    begin
                        $display("%0t position mismatch: expected %0d actual %0d",
                                 $time, rp.position, position);
                        mismatch_count++;
                    end
                    if (status !== rp.status)
                    begin
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, rp.status, status);
                        mismatch_count++;
                    end
                    if (used_count !== rp.used_count)
                    begin
                        $display("%0t used_count mismatch: expected %0d actual %0d",
                                 $time, rp.used_count, used_count);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // hold the receiver off midway, while the sender keeps offering items
    initial
    begin
        while (items_total == 0 || items_accepted < items_total / 2)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #(20 * TIMEOUT_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int mode;
        int pick;
        logic dup_bias;

        // directed: empty table cases, extremes, duplicates, clamping, spare code
        queue_request(ACT_FIND,   32'sd0, 1'b0, 1'b0, 6'd0, 7'd0);
        queue_request(ACT_FIND,   32'sd0, 1'b0, 1'b1, 6'd0, 7'd0);
        queue_request(ACT_REMOVE, 32'sd0, 1'b0, 1'b0, 6'd0, 7'd1);
        queue_request(ACT_SPARE,  32'sd0, 1'b0, 1'b0, 6'd0, 7'd0);
        queue_request(ACT_INSERT, 32'sd0, 1'b0, 1'b0, 6'd0, 7'd0);
        queue_request(ACT_INSERT, 32'sh7fff_ffff, 1'b0, 1'b0, 6'd0, 7'd0);
        queue_request(ACT_INSERT, 32'sh8000_0000, 1'b0, 1'b0, 6'd0, 7'd0);
        queue_request(ACT_INSERT, -32'sd1, 1'b0, 1'b0, 6'd0, 7'd0);
        queue_request(ACT_INSERT, 32'sd0, 1'b0, 1'b0, 6'd0, 7'd0);
        queue_request(ACT_INSERT, 32'sd0, 1'b1, 1'b0, 6'd0, 7'd0);
        queue_request(ACT_FIND,   32'sd0, 1'b0, 1'b0, 6'd0, 7'd0);
        queue_request(ACT_FIND,   32'sd5, 1'b0, 1'b0, 6'd0, 7'd0);
        queue_request(ACT_FIND,   32'sd5, 1'b0, 1'b1, 6'd0, 7'd0);
        queue_request(ACT_FIND,   32'sh7fff_ffff, 1'b0, 1'b1, 6'd0, 7'd0);
        queue_request(ACT_FIND,   32'sh8000_0000, 1'b0, 1'b0, 6'd0, 7'd0);
        queue_request(ACT_REMOVE, 32'sd0, 1'b0, 1'b0, 6'd2, 7'd0);
        queue_request(ACT_REMOVE, 32'sd0, 1'b0, 1'b0, 6'd63, 7'd64);
        queue_request(ACT_REMOVE, 32'sd0, 1'b0, 1'b0, 6'd1, 7'd2);
        queue_request(ACT_INSERT, 32'sh8000_0000, 1'b0, 1'b0, 6'd0, 7'd0);
        queue_request(ACT_FIND,   32'sh7fff_ffff, 1'b0, 1'b1, 6'd0, 7'd0);
        queue_request(ACT_REMOVE, 32'sd0, 1'b0, 1'b0, 6'd0, 7'd64);
        queue_request(ACT_SPARE,  -32'sd1, 1'b1, 1'b1, 6'd63, 7'd127);

        // random: segments alternate between filling, mixing and draining
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            mode = (n / SEGMENT_ITEMS) % 4;
            pick = $urandom_range(99);
            dup_bias = ($urandom_range(99) < ((mode < 2) ? 70 : 30));
            if ((mode < 2 && pick < 75) || (mode == 2 && pick < 40) || (mode == 3 && pick < 20))
                queue_request(ACT_INSERT, random_key(), dup_bias, 1'($urandom_range(1)),
                              IDX_W'($urandom_range(63)), CNT_W'($urandom_range(127)));
            else if ((mode < 2 && pick < 90) || (mode == 2 && pick < 75)
                     || (mode == 3 && pick < 50))
                queue_request(ACT_FIND, random_key(), 1'($urandom_range(1)),
                              1'($urandom_range(1)), IDX_W'($urandom_range(63)),
                              CNT_W'($urandom_range(127)));
            else if (pick < 97)
                queue_request(ACT_REMOVE, $urandom, 1'($urandom_range(1)),
                              1'($urandom_range(1)), IDX_W'($urandom_range(63)),
                              random_remove_count());
            else
                queue_request(ACT_SPARE, $urandom, 1'($urandom_range(1)),
                              1'($urandom_range(1)), IDX_W'($urandom_range(63)),
                              CNT_W'($urandom_range(127)));
        end
        items_total = pending_requests.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // all items taken and all replies seen, then let the block settle
        while (items_accepted < items_total || predicted_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && predicted_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/skt_pkg.sv
rtl/skt_ram.sv
rtl/skt_ctrl.sv
rtl/skt_datapath.sv
rtl/sorted_key_table.sv
rtl/skt_checker.sv
tb/tb.sv
